/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define GRLB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define GRLB_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

`endif

/* rtl/core/grlb_pkg.sv */
// ----------------------------------------------------------------------------
// grlb_pkg
// Shared constants, command/status types and a saturating-add helper of the load balancer.
// ----------------------------------------------------------------------------
package grlb_pkg;

  localparam int MAX_WORKERS = 32;
  localparam int MAX_HELPERS = 16;
  localparam int WIDX_W = $clog2(MAX_WORKERS);
  localparam int WCNT_W = $clog2(MAX_WORKERS + 1);
  localparam int HIDX_W = $clog2(MAX_HELPERS);
  localparam int HCNT_W = $clog2(MAX_HELPERS + 1);
  localparam int TIME_W = 32;
  localparam int T_W = 48;
  localparam int IPN_W = 10;
  localparam int IMG_W = 15;
  localparam int ITER_W = 16;
  localparam int HN_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_HELPER_NODES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGES_PER_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INLINE_ALLOWED = 2'd2;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
  localparam logic [OP_W-1:0] OP_DONE   = 4'd2;
  localparam logic [OP_W-1:0] OP_SKEY   = 4'd3;
  localparam logic [OP_W-1:0] OP_SCMP   = 4'd4;
  localparam logic [OP_W-1:0] OP_SWR    = 4'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd6;
  localparam logic [OP_W-1:0] OP_ASTART = 4'd7;
  localparam logic [OP_W-1:0] OP_ASCAN  = 4'd8;
  localparam logic [OP_W-1:0] OP_AWR    = 4'd9;
  localparam logic [OP_W-1:0] OP_PA     = 4'd10;
  localparam logic [OP_W-1:0] OP_PB     = 4'd11;
  localparam logic [OP_W-1:0] OP_RBW    = 4'd12;
  localparam logic [OP_W-1:0] OP_RBH    = 4'd13;
  localparam logic [OP_W-1:0] OP_RBC    = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WIDX_W-1:0] a;
    logic [WIDX_W-1:0] b;
    logic              hsel;
  } cmd_t;

  typedef struct packed {
    logic [WCNT_W-1:0] n;
    logic [HCNT_W-1:0] nh;
    logic              inl;
    logic              rb_stop;
  } sts_t;

  function automatic logic [T_W-1:0] sat_add(input logic [T_W-1:0] x,
                                             input logic [T_W-1:0] y);
    logic [T_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[T_W] ? {T_W{1'b1}} : s[T_W-1:0];
  endfunction

endpackage

/* rtl/core/greedy_render_load_balancer.sv */
// ----------------------------------------------------------------------------
// greedy_render_load_balancer
// Greedy least-loaded assignment of worker render loads to helper nodes,
// with optional image rebalancing back to workers.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  s_axis   | in        | one worker estimate; tlast starts the pass
//  m_axis   | out       | one worker or helper result; tlast on the last one
//  cfg      | in        | register write, no read-back
//
//  Estimates load while idle. The final estimate starts a pass: sort, clear,
//  assignment, push, then rebalance steps when inline is allowed; n+nh result
//  transactions follow.
//  s_axis is not ready from the final estimate until the last result is taken.
//  Results wait in place while m_axis_tready is low.
//  Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module greedy_render_load_balancer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [63:0]                          s_axis_tdata, // sim_est, image_time
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // node_number, assigned_helper, image_total, guard_error
  output logic [31:0]                          m_axis_tdata,
  output logic                                 m_axis_tuser, // is_helper
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [grlb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [grlb_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import grlb_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [4:0]        node_number;
  logic [HIDX_W-1:0] assigned_helper;
  logic [IMG_W-1:0]  image_total;
  logic              guard_error;

  grlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  grlb_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .sim_est_i         (s_axis_tdata[31:0]),
    .image_time_i      (s_axis_tdata[63:32]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .is_helper_o       (m_axis_tuser),
    .node_number_o     (node_number),
    .assigned_helper_o (assigned_helper),
    .image_total_o     (image_total),
    .guard_error_o     (guard_error),
    .last_result_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, guard_error, image_total, assigned_helper, node_number};

endmodule

/* rtl/core/grlb_datapath.sv */
// ----------------------------------------------------------------------------
// grlb_datapath
// Estimate stores, sort, assignment, push and rebalance arithmetic.
// ----------------------------------------------------------------------------
module grlb_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [grlb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [grlb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [grlb_pkg::TIME_W-1:0]      sim_est_i,
  input  logic [grlb_pkg::TIME_W-1:0]      image_time_i,
  input  grlb_pkg::cmd_t                   cmd_i,
  output grlb_pkg::sts_t                   sts_o,
  output logic                             is_helper_o,
  output logic [4:0]                       node_number_o,
  output logic [grlb_pkg::HIDX_W-1:0]      assigned_helper_o,
  output logic [grlb_pkg::IMG_W-1:0]       image_total_o,
  output logic                             guard_error_o,
  output logic                             last_result_o
);
  import grlb_pkg::*;

  logic [HN_W-1:0]   hn_q;
  logic [IPN_W-1:0]  ic_q;
  logic              inl_en_q;
  logic [WCNT_W-1:0] wc_q;
  logic [ITER_W-1:0] iter_q;
  logic [ITER_W-1:0] lim_q;
  logic              guard_q;

  logic [TIME_W-1:0] sim_q  [MAX_WORKERS];
  logic [TIME_W-1:0] img_q  [MAX_WORKERS];
  logic [WIDX_W-1:0] ord_q  [MAX_WORKERS];
  logic [HIDX_W-1:0] hw_q   [MAX_WORKERS];
  logic [T_W-1:0]    hc_q   [MAX_HELPERS];
  logic [T_W-1:0]    ht_q   [MAX_HELPERS];
  logic [T_W-1:0]    inl_q  [MAX_WORKERS];
  logic [IPN_W-1:0]  wimg_q [MAX_WORKERS];
  logic [IMG_W-1:0]  himg_q [MAX_HELPERS];

  logic [TIME_W:0]     keyi_q;
  logic [WIDX_W-1:0]   pos_q;
  logic [WIDX_W-1:0]   w_q;
  logic [HIDX_W-1:0]   best_q;
  logic [T_W-1:0]      bestc_q;
  logic [HIDX_W-1:0]   ph_q;
  logic [T_W-1:0]      prod_q;
  logic [T_W:0]        maxw_q;
  logic [T_W:0]        minv_q;
  logic [WIDX_W-1:0]   m_q;
  logic [T_W-1:0]      maxh_q;

  logic [WIDX_W-1:0] ia;
  logic [WIDX_W-1:0] ib;
  logic [HIDX_W-1:0] hb;
  logic [HCNT_W-1:0] nh;
  logic [TIME_W:0]   key_a;
  logic [TIME_W:0]   key_b;
  logic [T_W:0]      t_a;
  logic [HIDX_W-1:0] hs;
  logic              more;
  logic              empty;
  logic [ITER_W-1:0] iter_n;
  logic              grd;
  logic              wfull;
  logic              go;
  logic [IMG_W:0]    himg_sum;

  assign ia = cmd_i.a;
  assign ib = cmd_i.b;
  assign hb = cmd_i.b[HIDX_W-1:0];

  always_comb begin
    if (hn_q == '0) begin
      nh = HCNT_W'(1);
    end else if (hn_q > HN_W'(MAX_HELPERS)) begin
      nh = HCNT_W'(MAX_HELPERS);
    end else begin
      nh = HCNT_W'(hn_q);
    end
  end

  assign key_a    = {1'b0, sim_q[ia]} + {1'b0, img_q[ia]};
  assign key_b    = {1'b0, sim_q[ib]} + {1'b0, img_q[ib]};
  assign t_a      = {1'b0, inl_q[ia]} + (T_W + 1)'(sim_q[ia]);
  assign hs       = hw_q[m_q];
  assign more     = maxw_q < {1'b0, maxh_q};
  assign empty    = himg_q[hs] == '0;
  assign iter_n   = iter_q + ITER_W'(1);
  assign grd      = iter_n > lim_q;
  assign wfull    = ({1'b0, wimg_q[m_q]} + (IPN_W + 1)'(1)) == {1'b0, ic_q};
  assign go       = more && !empty;
  assign himg_sum = {1'b0, himg_q[ph_q]} + (IMG_W + 1)'(ic_q);

  assign sts_o.n       = wc_q;
  assign sts_o.nh      = nh;
  assign sts_o.inl     = inl_en_q;
  assign sts_o.rb_stop = !go || grd || wfull;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hn_q     <= HN_W'(1);
      ic_q     <= IPN_W'(1);
      inl_en_q <= 1'b1;
      wc_q     <= '0;
      iter_q   <= '0;
      lim_q    <= '0;
      guard_q  <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        inl_q[i]  <= '0;
        wimg_q[i] <= '0;
      end
      for (int h = 0; h < MAX_HELPERS; h++) begin
        hc_q[h]   <= '0;
        ht_q[h]   <= '0;
        himg_q[h] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HELPER_NODES:    hn_q <= cfg_data_i[HN_W-1:0];
          CFG_IMAGES_PER_NODE: ic_q <= cfg_data_i[IPN_W-1:0];
          CFG_INLINE_ALLOWED:  inl_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (wc_q < WCNT_W'(MAX_WORKERS)) wc_q <= wc_q + WCNT_W'(1);
        end
        OP_DONE: wc_q <= '0;
        OP_CLEAR: begin
          iter_q  <= '0;
          guard_q <= 1'b0;
          lim_q   <= ITER_W'(ic_q) * ITER_W'(wc_q);
          for (int i = 0; i < MAX_WORKERS; i++) begin
            inl_q[i]  <= '0;
            wimg_q[i] <= '0;
          end
          for (int h = 0; h < MAX_HELPERS; h++) begin
            hc_q[h]   <= '0;
            ht_q[h]   <= '0;
            himg_q[h] <= '0;
          end
        end
        OP_AWR: hc_q[best_q] <= sat_add(hc_q[best_q], T_W'(img_q[w_q]));
        OP_PB: begin
          ht_q[ph_q]   <= sat_add(ht_q[ph_q], prod_q);
          himg_q[ph_q] <= himg_sum[IMG_W] ? {IMG_W{1'b1}} : himg_sum[IMG_W-1:0];
        end
        OP_RBC: begin
          if (go) begin
            ht_q[hs]     <= (ht_q[hs] > T_W'(img_q[m_q])) ?
                            ht_q[hs] - T_W'(img_q[m_q]) : '0;
            himg_q[hs]   <= himg_q[hs] - IMG_W'(1);
            inl_q[m_q]   <= sat_add(inl_q[m_q], T_W'(img_q[m_q]));
            wimg_q[m_q]  <= wimg_q[m_q] + IPN_W'(1);
            iter_q       <= iter_n;
            if (grd) guard_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        if (wc_q < WCNT_W'(MAX_WORKERS)) begin
          sim_q[wc_q[WIDX_W-1:0]] <= sim_est_i;
          img_q[wc_q[WIDX_W-1:0]] <= image_time_i;
        end
      end
      OP_SKEY: begin
        keyi_q <= key_a;
        pos_q  <= '0;
      end
      OP_SCMP: begin
        if (key_b > keyi_q || (key_b == keyi_q && ib < ia)) pos_q <= pos_q + WIDX_W'(1);
      end
      OP_SWR: ord_q[pos_q] <= ia;
      OP_ASTART: begin
        w_q     <= ord_q[ia];
        best_q  <= '0;
        bestc_q <= hc_q[0];
      end
      OP_ASCAN: begin
        if (hc_q[hb] < bestc_q) begin
          best_q  <= hb;
          bestc_q <= hc_q[hb];
        end
      end
      OP_AWR: hw_q[w_q] <= best_q;
      OP_PA: begin
        ph_q   <= hw_q[ia];
        prod_q <= T_W'(img_q[ia]) * T_W'(ic_q);
      end
      OP_RBW: begin
        if (ia == '0) begin
          maxw_q <= t_a;
          minv_q <= t_a;
          m_q    <= '0;
        end else begin
          if (t_a > maxw_q) maxw_q <= t_a;
          if (t_a < minv_q) begin
            minv_q <= t_a;
            m_q    <= ia;
          end
        end
      end
      OP_RBH: begin
        if (hb == '0 || ht_q[hb] > maxh_q) maxh_q <= ht_q[hb];
      end
      default: ;
    endcase
  end

  always_comb begin
    is_helper_o   = cmd_i.hsel;
    guard_error_o = guard_q;
    if (cmd_i.hsel) begin
      node_number_o     = ib;
      assigned_helper_o = '0;
      image_total_o     = himg_q[hb];
      last_result_o     = HCNT_W'(ib) == (nh - HCNT_W'(1));
    end else begin
      node_number_o     = ia;
      assigned_helper_o = hw_q[ia];
      image_total_o     = IMG_W'(wimg_q[ia]);
      last_result_o     = 1'b0;
    end
  end

endmodule

/* rtl/core/grlb_ctrl.sv */
// ----------------------------------------------------------------------------
// grlb_ctrl
// Sequencer: load, sort, assign, push, rebalance and result phases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grlb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  grlb_pkg::sts_t sts_i,
  output grlb_pkg::cmd_t cmd_o
);
  import grlb_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_SKEY   = 4'd1;
  localparam logic [ST_W-1:0] S_SCMP   = 4'd2;
  localparam logic [ST_W-1:0] S_SWR    = 4'd3;
  localparam logic [ST_W-1:0] S_CLEAR  = 4'd4;
  localparam logic [ST_W-1:0] S_ASTART = 4'd5;
  localparam logic [ST_W-1:0] S_ASCAN  = 4'd6;
  localparam logic [ST_W-1:0] S_AWR    = 4'd7;
  localparam logic [ST_W-1:0] S_PA     = 4'd8;
  localparam logic [ST_W-1:0] S_PB     = 4'd9;
  localparam logic [ST_W-1:0] S_RBW    = 4'd10;
  localparam logic [ST_W-1:0] S_RBH    = 4'd11;
  localparam logic [ST_W-1:0] S_RBC    = 4'd12;
  localparam logic [ST_W-1:0] S_EMW    = 4'd13;
  localparam logic [ST_W-1:0] S_EMH    = 4'd14;

  logic [ST_W-1:0]   state_q, state_d;
  logic [WIDX_W-1:0] a_q, a_d;
  logic [WIDX_W-1:0] b_q, b_d;
  logic              a_end;
  logic              b_end;

  assign a_end = a_q == WIDX_W'(sts_i.n - WCNT_W'(1));
  assign b_end = b_q == WIDX_W'(sts_i.nh - HCNT_W'(1));

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_EMW || state_q == S_EMH;

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    cmd_o.op   = OP_NONE;
    cmd_o.a    = a_q;
    cmd_o.b    = b_q;
    cmd_o.hsel = state_q == S_EMH;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (in_last_i) begin
            state_d = S_SKEY;
            a_d     = '0;
          end
        end
      end
      S_SKEY: begin
        cmd_o.op = OP_SKEY;
        b_d      = '0;
        state_d  = S_SCMP;
      end
      S_SCMP: begin
        cmd_o.op = OP_SCMP;
        if (b_q == WIDX_W'(sts_i.n - WCNT_W'(1))) state_d = S_SWR;
        else b_d = b_q + WIDX_W'(1);
      end
      S_SWR: begin
        cmd_o.op = OP_SWR;
        if (a_end) begin
          state_d = S_CLEAR;
        end else begin
          a_d     = a_q + WIDX_W'(1);
          state_d = S_SKEY;
        end
      end
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        a_d      = '0;
        state_d  = S_ASTART;
      end
      S_ASTART: begin
        cmd_o.op = OP_ASTART;
        b_d      = WIDX_W'(1);
        state_d  = (sts_i.nh == HCNT_W'(1)) ? S_AWR : S_ASCAN;
      end
      S_ASCAN: begin
        cmd_o.op = OP_ASCAN;
        if (b_end) state_d = S_AWR;
        else b_d = b_q + WIDX_W'(1);
      end
      S_AWR: begin
        cmd_o.op = OP_AWR;
        if (a_end) begin
          a_d     = '0;
          state_d = S_PA;
        end else begin
          a_d     = a_q + WIDX_W'(1);
          state_d = S_ASTART;
        end
      end
      S_PA: begin
        cmd_o.op = OP_PA;
        state_d  = S_PB;
      end
      S_PB: begin
        cmd_o.op = OP_PB;
        if (a_end) begin
          a_d     = '0;
          state_d = sts_i.inl ? S_RBW : S_EMW;
        end else begin
          a_d     = a_q + WIDX_W'(1);
          state_d = S_PA;
        end
      end
      S_RBW: begin
        cmd_o.op = OP_RBW;
        if (a_end) begin
          b_d     = '0;
          state_d = S_RBH;
        end else begin
          a_d = a_q + WIDX_W'(1);
        end
      end
      S_RBH: begin
        cmd_o.op = OP_RBH;
        if (b_end) state_d = S_RBC;
        else b_d = b_q + WIDX_W'(1);
      end
      S_RBC: begin
        cmd_o.op = OP_RBC;
        a_d      = '0;
        state_d  = sts_i.rb_stop ? S_EMW : S_RBW;
      end
      S_EMW: begin
        if (out_ready_i) begin
          if (a_end) begin
            b_d     = '0;
            state_d = S_EMH;
          end else begin
            a_d = a_q + WIDX_W'(1);
          end
        end
      end
      S_EMH: begin
        if (out_ready_i) begin
          if (b_end) begin
            cmd_o.op = OP_DONE;
            state_d  = S_IDLE;
          end else begin
            b_d = b_q + WIDX_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q     <= '0;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
    end
  end

  `GRLB_NEVER(a_in_out_excl, clk_i, rst_ni, in_ready_o && out_valid_o)
  `GRLB_ASSERT(a_last_starts, clk_i, rst_ni,
    (in_valid_i && in_ready_o && in_last_i) |=> (state_q == S_SKEY))
  `GRLB_ASSERT(a_rb_exit, clk_i, rst_ni,
    (state_q == S_RBC && sts_i.rb_stop) |=> (state_q == S_EMW && a_q == '0))

endmodule
